[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file jse_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge, including during reset.
`define JSE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

// Checked at every rising edge outside reset.
`define JSE_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`endif

[hw/rtl/jse_pkg.sv]
package jse_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned STEP_W     = 3;
  localparam int unsigned TOTAL_W    = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_QUOTE_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHARS    = 2'd1;

  localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF      = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_QUOTE   = 8'h22;
  localparam logic [BYTE_W-1:0] CH_BSLASH  = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] CH_LOWER_N = 8'h6E;
  localparam logic [BYTE_W-1:0] CH_LOWER_R = 8'h72;
  localparam logic [BYTE_W-1:0] CH_LOWER_T = 8'h74;
  localparam logic [BYTE_W-1:0] CH_LOWER_U = 8'h75;
  localparam logic [BYTE_W-1:0] CTRL_LIMIT = 8'h20;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    BODY_NONE,
    BODY_RAW,
    BODY_SHORT,
    BODY_UNI
  } body_kind_t;

  typedef struct packed {
    logic             open_q;
    logic             close_q;
    body_kind_t       kind;
    logic [BYTE_W-1:0] ch;
  } jse_req_t;

  function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] nib);
    logic [BYTE_W-1:0] res;
    if (nib < 4'd10) begin
      res = CH_ZERO + {4'd0, nib};
    end else begin
      res = CH_UPPER_A + {4'd0, nib} - 8'd10;
    end
    return res;
  endfunction

  function automatic logic [TOTAL_W-1:0] body_len(input body_kind_t kind);
    logic [TOTAL_W-1:0] res;
    case (kind)
      BODY_NONE:  res = 4'd0;
      BODY_RAW:   res = 4'd1;
      BODY_SHORT: res = 4'd2;
      BODY_UNI:   res = 4'd6;
      default:    res = 4'd0;
    endcase
    return res;
  endfunction

  function automatic logic [BYTE_W-1:0] short_letter(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] res;
    case (c)
      CH_TAB:  res = CH_LOWER_T;
      CH_LF:   res = CH_LOWER_N;
      CH_CR:   res = CH_LOWER_R;
      default: res = c;
    endcase
    return res;
  endfunction

  function automatic logic [BYTE_W-1:0] body_char(input body_kind_t kind,
                                                  input logic [BYTE_W-1:0] c,
                                                  input logic [STEP_W-1:0] pos);
    logic [BYTE_W-1:0] res;
    res = c;
    case (kind)
      BODY_SHORT: begin
        res = (pos == 3'd0) ? CH_BSLASH : short_letter(c);
      end
      BODY_UNI: begin
        case (pos)
          3'd0:    res = CH_BSLASH;
          3'd1:    res = CH_LOWER_U;
          3'd2:    res = CH_ZERO;
          3'd3:    res = CH_ZERO;
          3'd4:    res = hex_digit(c[7:4]);
          default: res = hex_digit(c[3:0]);
        endcase
      end
      default: res = c;
    endcase
    return res;
  endfunction

endpackage

[hw/rtl/json_string_escaper_unit.sv]
// With the queue empty and the output free, the first character of an accepted byte
// is written into the request queue and then into the output register.
// Throughput: one input byte per cycle while the request queue has room; the output
// register sends one character per cycle while not stalled; a byte that expands to
// n characters holds it until all are sent, and the QUEUE_DEPTH queue absorbs it.
// Reset (synchronous, active low) empties the queue, clears the output and the
// byte count, turns quoting off, removes the limit and marks the start of a string.
module json_string_escaper_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [jse_pkg::BYTE_W-1:0]        in_byte,
  input  logic                              in_last,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [jse_pkg::BYTE_W-1:0]        out_char,
  output logic                              out_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [jse_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [jse_pkg::COUNT_W-1:0]       cfg_data
);
  import jse_pkg::*;

  logic     q_full;
  logic     q_push;
  jse_req_t q_push_req;
  logic     q_pop;
  logic     q_head_valid;
  jse_req_t q_head_req;
  logic     accept;

  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign cfg_ready = 1'b1;

  jse_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .accept    (accept),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (q_push),
    .push_req  (q_push_req)
  );

  jse_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_req   (q_push_req),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_req   (q_head_req)
  );

  jse_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_req   (q_head_req),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_char   (out_char),
    .out_last   (out_last)
  );

endmodule

[hw/rtl/jse_fifo.sv]
module jse_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  jse_pkg::jse_req_t    push_req,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output jse_pkg::jse_req_t    head_req
);
  import jse_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  jse_req_t         slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full       = (count_r == FULL_CNT);
  assign head_valid = (count_r != '0);
  assign head_req   = slots_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_req;
    end
  end

endmodule

[hw/rtl/jse_front.sv]
module jse_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              accept,
  input  logic [jse_pkg::BYTE_W-1:0]        in_byte,
  input  logic                              in_last,
  input  logic                              cfg_write,
  input  logic [jse_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [jse_pkg::COUNT_W-1:0]       cfg_data,
  output logic                              push,
  output jse_pkg::jse_req_t                 push_req
);
  import jse_pkg::*;

  logic               quote_en_r, quote_en_nxt;
  logic [COUNT_W-1:0] max_chars_r, max_chars_nxt;
  logic               at_start_r, at_start_nxt;
  logic [COUNT_W-1:0] taken_r, taken_nxt;
  logic [COUNT_W-1:0] count_base;
  logic               kept;
  logic               is_short;
  body_kind_t         kind;

  assign count_base = at_start_r ? '0 : taken_r;
  assign kept       = (max_chars_r == '0) || (count_base < max_chars_r);
  assign is_short   = (in_byte == CH_TAB) || (in_byte == CH_LF) || (in_byte == CH_CR) ||
                      (in_byte == CH_QUOTE) || (in_byte == CH_BSLASH);

  always_comb begin
    if (!kept) begin
      kind = BODY_NONE;
    end else if (!quote_en_r) begin
      kind = BODY_RAW;
    end else if (is_short) begin
      kind = BODY_SHORT;
    end else if (in_byte < CTRL_LIMIT) begin
      kind = BODY_UNI;
    end else begin
      kind = BODY_RAW;
    end
  end

  always_comb begin
    push_req.open_q  = quote_en_r && at_start_r;
    push_req.close_q = quote_en_r && in_last;
    push_req.kind    = kind;
    push_req.ch      = in_byte;
    push = accept && in_valid &&
           (push_req.open_q || push_req.close_q || (kind != BODY_NONE));
  end

  always_comb begin
    at_start_nxt = at_start_r;
    taken_nxt    = taken_r;
    if (accept) begin
      at_start_nxt = in_last;
      taken_nxt    = (kept && (count_base != COUNT_MAX)) ? count_base + 1'b1 : count_base;
    end
  end

  always_comb begin
    quote_en_nxt  = quote_en_r;
    max_chars_nxt = max_chars_r;
    if (cfg_write) begin
      case (cfg_index)
        CFG_QUOTE_ENABLE: quote_en_nxt  = cfg_data[0];
        CFG_MAX_CHARS:    max_chars_nxt = cfg_data;
        default:          quote_en_nxt  = quote_en_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quote_en_r  <= 1'b0;
      max_chars_r <= '0;
      at_start_r  <= 1'b1;
      taken_r     <= '0;
    end else begin
      quote_en_r  <= quote_en_nxt;
      max_chars_r <= max_chars_nxt;
      at_start_r  <= at_start_nxt;
      taken_r     <= taken_nxt;
    end
  end

endmodule

[hw/rtl/jse_back.sv]
module jse_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       head_valid,
  input  jse_pkg::jse_req_t          head_req,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [jse_pkg::BYTE_W-1:0] out_char,
  output logic                       out_last
);
  import jse_pkg::*;

  logic [STEP_W-1:0]  step_r, step_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]  out_char_r, out_char_nxt;
  logic               out_last_r, out_last_nxt;
  logic [TOTAL_W-1:0] total;
  logic [STEP_W-1:0]  body_pos;
  logic [TOTAL_W-1:0] body_end;
  logic               slot_free;
  logic               emit;
  logic               is_final;
  logic [BYTE_W-1:0]  cur_char;

  assign total     = {3'd0, head_req.open_q} + body_len(head_req.kind) +
                     {3'd0, head_req.close_q};
  assign body_pos  = step_r - {2'd0, head_req.open_q};
  assign body_end  = {3'd0, head_req.open_q} + body_len(head_req.kind);
  assign is_final  = ({1'b0, step_r} == total - 1'b1);
  assign slot_free = !out_valid_r || !out_stall;
  assign emit      = head_valid && slot_free;
  assign pop       = emit && is_final;

  always_comb begin
    if (head_req.open_q && (step_r == '0)) begin
      cur_char = CH_QUOTE;
    end else if ({1'b0, step_r} < body_end) begin
      cur_char = body_char(head_req.kind, head_req.ch, body_pos);
    end else begin
      cur_char = CH_QUOTE;
    end
  end

  always_comb begin
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      step_nxt      = is_final ? '0 : step_r + 1'b1;
      out_valid_nxt = 1'b1;
      out_char_nxt  = cur_char;
      out_last_nxt  = is_final;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

endmodule

[hw/rtl/jse_checker.sv]
`include "assert_macros.svh"

module jse_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_char,
  input logic       out_last
);

  `JSE_ASSERT(a_reset_clears_out, !rst_n |=> !out_valid, "Output valid after reset")
  `JSE_ASSERT(a_reset_empties_queue, !rst_n |=> !in_stall, "Input stalled after reset")
  `JSE_ASSERT_RST(a_out_valid_holds, out_valid && out_stall |=> out_valid, "Valid dropped")
  `JSE_ASSERT_RST(a_out_payload_holds,
                  out_valid && out_stall |=> $stable(out_char) && $stable(out_last),
                  "Stalled payload changed")

endmodule

bind json_string_escaper_unit jse_checker u_jse_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_char  (out_char),
  .out_last  (out_last)
);
